// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// ante implies cons in the next cycle
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/btle_pkg.sv =====
// ----------------------------------------------------------------------------
// btle_pkg
// Types and constants shared by the binary trie lookup engine.
// ----------------------------------------------------------------------------
package btle_pkg;

    localparam int POOL_NODES    = 1024;
    localparam int MAX_KEY_BYTES = 4;
    localparam int VALUE_BITS    = 32;
    localparam int KEY_W         = 32;
    localparam int DATA_W        = 32;
    localparam int KB_W          = 3;
    localparam int FUNC_W        = 2;

    localparam int NODE_W  = $clog2(POOL_NODES);
    localparam int CNT_W   = $clog2(POOL_NODES + 1);
    localparam int LVL_W   = $clog2(MAX_KEY_BYTES * 8 + 1);
    localparam int KIDX_W  = $clog2(KEY_W);

    localparam int S_TDATA_W = 2 * DATA_W;
    localparam int M_TDATA_W = ((DATA_W + 2 + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    typedef struct packed {
        logic                  has_val;
        logic [VALUE_BITS-1:0] val;
        logic [NODE_W-1:0]     right;
        logic [NODE_W-1:0]     left;
    } node_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_root;
        logic alloc_root;
        logic follow;
        logic alloc;
        logic write_cur;
        logic write_leaf;
        logic clear;
        logic res_set;
        logic res_hit;
        logic res_full;
        logic out_push;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] in_func;
        logic [FUNC_W-1:0] func;
        logic              root_present;
        logic              level_done;
        logic              child_zero;
        logic              pool_full;
        logic              out_free;
    } sts_t;

endpackage

// ===== src/binary_trie_lookup_engine.sv =====
// Search/insert: dispatch in ST_IDLE, one trie level per step in ST_WALK (key_bytes*8
// levels, up to 32), a leaf step, then the result push in ST_RESP once the output is
// free. Clear, unused codes and a search of an empty trie go from dispatch straight to
// ST_RESP. A new item is taken only in ST_IDLE. Reset (rst_n low, async) empties the trie
// and sets key_bytes to 4; node memory is not cleared, nodes are written when allocated.
// ----------------------------------------------------------------------------
// binary_trie_lookup_engine
// Exact-match binary trie search/insert/clear over a node pool.
// ----------------------------------------------------------------------------
module binary_trie_lookup_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [btle_pkg::S_TDATA_W-1:0]  s_tdata,   // key[31:0], value[63:32]
    input  logic [btle_pkg::FUNC_W-1:0]     s_tuser,   // func[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [btle_pkg::M_TDATA_W-1:0]  m_tdata,   // found[0], result_value[32:1], status[33]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [btle_pkg::KB_W-1:0]       cfg_data   // key_bytes[2:0]
);
    import btle_pkg::*;

    cmd_t cmd;
    sts_t sts;

    btle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    btle_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== src/btle_ctrl.sv =====
// ----------------------------------------------------------------------------
// btle_ctrl
// Sequencer: dispatches each item and steps the trie walk one level a cycle.
// ----------------------------------------------------------------------------
module btle_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  btle_pkg::sts_t sts,
    output btle_pkg::cmd_t cmd
);
    import btle_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    priority if (sts.in_func == FUNC_SEARCH && sts.root_present)
                    begin
                        cmd.rd_root = 1'b1;
                        state_next  = ST_WALK;
                    end
                    else if (sts.in_func == FUNC_INSERT)
                    begin
                        cmd.rd_root    = sts.root_present;
                        cmd.alloc_root = !sts.root_present;
                        state_next     = ST_WALK;
                    end
                    else
                    begin
                        cmd.clear   = (sts.in_func == FUNC_CLEAR);
                        cmd.res_set = 1'b1;
                        state_next  = ST_RESP;
                    end
                end
            end
            ST_WALK:
            begin
                priority if (sts.level_done)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_hit    = (sts.func == FUNC_SEARCH);
                    cmd.write_leaf = (sts.func == FUNC_INSERT);
                    state_next     = ST_RESP;
                end
                else if (!sts.child_zero)
                begin
                    cmd.follow = 1'b1;
                end
                else if (sts.func == FUNC_SEARCH)
                begin
                    cmd.res_set = 1'b1;
                    state_next  = ST_RESP;
                end
                else if (!sts.pool_full)
                begin
                    cmd.alloc = 1'b1;
                end
                else
                begin
                    cmd.write_cur = 1'b1;
                    cmd.res_set   = 1'b1;
                    cmd.res_full  = 1'b1;
                    state_next    = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_push = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/btle_dp.sv =====
// ----------------------------------------------------------------------------
// btle_dp
// Datapath: node memory, walk registers, allocator, config and result regs.
// ----------------------------------------------------------------------------
module btle_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  btle_pkg::cmd_t                  cmd,
    output btle_pkg::sts_t                  sts,
    input  logic [btle_pkg::FUNC_W-1:0]     s_tuser,
    input  logic [btle_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [btle_pkg::KB_W-1:0]       cfg_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [btle_pkg::M_TDATA_W-1:0]  m_tdata
);
    import btle_pkg::*;

    node_t mem [POOL_NODES];

    logic [FUNC_W-1:0]     func_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [DATA_W-1:0]     value_reg;
    logic [LVL_W-1:0]      levels_reg;
    logic [LVL_W-1:0]      level_reg;
    logic [LVL_W-1:0]      level_next;
    logic [NODE_W-1:0]     cur_reg;
    logic [NODE_W-1:0]     cur_next;
    logic                  fresh_reg;
    logic                  fresh_next;
    logic [CNT_W-1:0]      next_free_reg;
    logic [CNT_W-1:0]      next_free_next;
    logic                  root_present_reg;
    logic                  root_present_next;
    logic [KB_W-1:0]       key_bytes_reg;
    node_t                 rd_data_reg;

    logic                  pend_found_reg;
    logic [DATA_W-1:0]     pend_value_reg;
    logic                  pend_status_reg;
    logic                  out_valid_reg;
    logic                  out_found_reg;
    logic [DATA_W-1:0]     out_value_reg;
    logic                  out_status_reg;

    logic [KB_W-1:0]       kb_sat;
    logic [LVL_W-1:0]      levels_in;
    node_t                 node_cur;
    logic                  key_bit;
    logic [NODE_W-1:0]     child;
    logic                  rd_en;
    logic [NODE_W-1:0]     rd_addr;
    logic                  wr_en;
    node_t                 wr_data;
    logic                  hit;

    assign cfg_ready = 1'b1;

    assign kb_sat    = (key_bytes_reg > KB_W'(MAX_KEY_BYTES)) ? KB_W'(MAX_KEY_BYTES)
                                                             : key_bytes_reg;
    assign levels_in = LVL_W'({kb_sat, 3'b000});

    assign node_cur = fresh_reg ? node_t'('0) : rd_data_reg;
    assign key_bit  = (level_reg < LVL_W'(KEY_W)) ? key_reg[level_reg[KIDX_W-1:0]] : 1'b0;
    assign child    = key_bit ? node_cur.right : node_cur.left;
    assign hit      = cmd.res_hit && node_cur.has_val;

    assign sts.in_func      = s_tuser;
    assign sts.func         = func_reg;
    assign sts.root_present = root_present_reg;
    assign sts.level_done   = (level_reg == levels_reg);
    assign sts.child_zero   = (child == '0) || ({1'b0, child} >= (NODE_W+1)'(POOL_NODES));
    assign sts.pool_full    = (next_free_reg >= CNT_W'(POOL_NODES));
    assign sts.out_free     = !out_valid_reg || m_tready;

    assign rd_en   = cmd.rd_root || cmd.follow;
    assign rd_addr = cmd.follow ? child : '0;
    assign wr_en   = cmd.alloc || cmd.write_cur || cmd.write_leaf;

    always_comb
    begin
        wr_data = node_cur;
        if (cmd.alloc)
        begin
            if (key_bit)
            begin
                wr_data.right = next_free_reg[NODE_W-1:0];
            end
            else
            begin
                wr_data.left = next_free_reg[NODE_W-1:0];
            end
        end
        if (cmd.write_leaf)
        begin
            wr_data.val     = value_reg[VALUE_BITS-1:0];
            wr_data.has_val = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cur_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        level_next        = level_reg;
        cur_next          = cur_reg;
        fresh_next        = fresh_reg;
        next_free_next    = next_free_reg;
        root_present_next = root_present_reg;
        if (cmd.rd_root)
        begin
            level_next = '0;
            cur_next   = '0;
            fresh_next = 1'b0;
        end
        if (cmd.alloc_root)
        begin
            level_next        = '0;
            cur_next          = '0;
            fresh_next        = 1'b1;
            next_free_next    = CNT_W'(1);
            root_present_next = 1'b1;
        end
        if (cmd.follow)
        begin
            level_next = level_reg + LVL_W'(1);
            cur_next   = child;
            fresh_next = 1'b0;
        end
        if (cmd.alloc)
        begin
            level_next     = level_reg + LVL_W'(1);
            cur_next       = next_free_reg[NODE_W-1:0];
            fresh_next     = 1'b1;
            next_free_next = next_free_reg + CNT_W'(1);
        end
        if (cmd.clear)
        begin
            next_free_next    = '0;
            root_present_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg    <= '0;
            root_present_reg <= 1'b0;
            key_bytes_reg    <= KB_W'(MAX_KEY_BYTES);
            out_valid_reg    <= 1'b0;
            level_reg        <= '0;
            cur_reg          <= '0;
            fresh_reg        <= 1'b0;
        end
        else
        begin
            next_free_reg    <= next_free_next;
            root_present_reg <= root_present_next;
            level_reg        <= level_next;
            cur_reg          <= cur_next;
            fresh_reg        <= fresh_next;
            if (cfg_valid)
            begin
                key_bytes_reg <= cfg_data;
            end
            if (cmd.out_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= s_tuser;
            key_reg    <= s_tdata[KEY_W-1:0];
            value_reg  <= s_tdata[S_TDATA_W-1:KEY_W];
            levels_reg <= levels_in;
        end
        if (cmd.res_set)
        begin
            pend_found_reg  <= hit;
            pend_value_reg  <= hit ? DATA_W'(node_cur.val) : '0;
            pend_status_reg <= cmd.res_full;
        end
        if (cmd.out_push)
        begin
            out_found_reg  <= pend_found_reg;
            out_value_reg  <= pend_value_reg;
            out_status_reg <= pend_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_status_reg, out_value_reg, out_found_reg});

endmodule

// ===== src/btle_checker.sv =====
// ----------------------------------------------------------------------------
// btle_checker
// Port-level checks for the trie engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btle_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [btle_pkg::M_TDATA_W-1:0]  m_tdata
);
    import btle_pkg::*;

    // held result stays up
    `CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    // one item at a time
    `CHK_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
    // a miss returns zero value
    `CHK_SAME(a_miss_zero, m_tvalid && !m_tdata[0], m_tdata[DATA_W:1] == '0)
    // a hit never reports pool full
    `CHK_SAME(a_hit_ok, m_tvalid && m_tdata[0], !m_tdata[DATA_W+1])

endmodule

bind binary_trie_lookup_engine btle_checker u_btle_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for binary_trie_lookup_engine. A shadow trie predicts
// each search, insert, clear and unused-code item. Directed cases come first,
// then pool exhaustion and random key sets over every key_bytes setting, then
// a long output stall. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import btle_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int IDLE_PCT    = 14;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;
    localparam int ITEM_TARGET = 1250;
    localparam int HOLD_ITEMS  = 16;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] value;
        logic              status;
    } lookup_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // key[31:0], value[63:32]
    logic [FUNC_W-1:0]    s_tuser   = '0;   // func[1:0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // found[0], result_value[32:1], status[33]
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [KB_W-1:0]      cfg_data  = '0;   // key_bytes[2:0]

    int  errors     = 0;
    int  items_sent = 0;
    int  hold_reqs  = 0;
    bit  steady     = 1'b0;
    lookup_result_t pending_results[$];

    // shadow trie
    int unsigned           left_of[POOL_NODES];
    int unsigned           right_of[POOL_NODES];
    logic [VALUE_BITS-1:0] stored_val[POOL_NODES];
    bit                    holds_val[POOL_NODES];
    int unsigned           nodes_used = 0;
    bit                    root_live  = 1'b0;
    logic [KB_W-1:0]       key_bytes  = 3'd4;

    binary_trie_lookup_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit grab_node(output int unsigned idx);
        if (nodes_used >= POOL_NODES)
            return 1'b0;
        idx = nodes_used;
        left_of[idx]    = 0;
        right_of[idx]   = 0;
        stored_val[idx] = '0;
        holds_val[idx]  = 1'b0;
        nodes_used++;
        return 1'b1;
    endfunction

    function automatic lookup_result_t predict_lookup(input logic [FUNC_W-1:0] func,
                                                      input logic [KEY_W-1:0] key,
                                                      input logic [DATA_W-1:0] value);
        lookup_result_t res;
        int unsigned    depth;
        int unsigned    at;
        int unsigned    nxt;
        int             i;
        res   = '0;
        depth = ((key_bytes > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(key_bytes)) * 8;
        at    = 0;
        case (func)
            FUNC_SEARCH:
            begin
                if (!root_live)
                    return res;
                for (i = 0; i < depth; i++)
                begin
                    nxt = key[i] ? right_of[at] : left_of[at];
                    if (nxt == 0)
                        return res;
                    at = nxt;
                end
                if (holds_val[at])
                begin
                    res.found = 1'b1;
                    res.value = stored_val[at];
                end
            end
            FUNC_INSERT:
            begin
                if (!root_live)
                begin
                    nodes_used = 0;
                    if (!grab_node(at))
                    begin
                        res.status = 1'b1;
                        return res;
                    end
                    root_live = 1'b1;
                end
                at = 0;
                for (i = 0; i < depth; i++)
                begin
                    nxt = key[i] ? right_of[at] : left_of[at];
                    if (nxt == 0)
                    begin
                        if (!grab_node(nxt))
                        begin
                            res.status = 1'b1;
                            return res;
                        end
                        if (key[i])
                            right_of[at] = nxt;
                        else
                            left_of[at] = nxt;
                    end
                    at = nxt;
                end
                stored_val[at] = value;
                holds_val[at]  = 1'b1;
            end
            FUNC_CLEAR:
            begin
                nodes_used = 0;
                root_live  = 1'b0;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < 100)
            $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic send_op(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                           input logic [DATA_W-1:0] value, output lookup_result_t want);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {value, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = predict_lookup(func, key, value);
        pending_results.push_back(want);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_key_bytes(input logic [KB_W-1:0] kb);
        cfg_valid <= 1'b1;
        cfg_data  <= kb;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        key_bytes = kb;
    endtask

    task automatic test_directed();
        lookup_result_t want;
        send_op(FUNC_SEARCH, 32'h0, 32'h0, want);                 // empty trie
        send_op(FUNC_INSERT, 32'h0, 32'h0, want);
        send_op(FUNC_SEARCH, 32'h0, 32'hFFFF_FFFF, want);
        send_op(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, want);
        send_op(FUNC_SEARCH, 32'hFFFF_FFFF, 32'h0, want);
        send_op(FUNC_SEARCH, 32'h7FFF_FFFF, 32'h0, want);         // miss at last level
        send_op(FUNC_SEARCH, 32'hFFFF_FFFE, 32'h0, want);
        send_op(FUNC_INSERT, 32'h8000_0001, 32'h1234_5678, want);
        send_op(FUNC_INSERT, 32'h8000_0001, 32'hA5A5_A5A5, want); // overwrite
        send_op(FUNC_SEARCH, 32'h8000_0001, 32'h0, want);
        send_op(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, want);
        send_op(FUNC_SEARCH, 32'hFFFF_FFFF, 32'h0, want);
        send_op(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, want);
        send_op(FUNC_SEARCH, 32'hFFFF_FFFF, 32'h0, want);
        send_op(FUNC_INSERT, 32'h0000_0001, 32'h0000_600D, want);
        wait_idle();
        set_key_bytes(3'd0);                                      // root is the leaf
        send_op(FUNC_SEARCH, 32'hDEAD_BEEF, 32'h0, want);         // empty leaf
        send_op(FUNC_INSERT, 32'h1234_5678, 32'h0BAD_F00D, want);
        send_op(FUNC_SEARCH, 32'hFFFF_FFFF, 32'h0, want);
        wait_idle();
        set_key_bytes(3'd7);                                      // saturates to 4 bytes
        send_op(FUNC_SEARCH, 32'h0000_0001, 32'h0, want);
        send_op(FUNC_SEARCH, 32'h8000_0001, 32'h0, want);
        wait_idle();
        set_key_bytes(3'd1);
        send_op(FUNC_INSERT, 32'h0000_00AB, 32'h0000_0011, want);
        send_op(FUNC_SEARCH, 32'hFFFF_FFAB, 32'h0, want);         // upper bits ignored
        wait_idle();
        set_key_bytes(3'd2);
        send_op(FUNC_SEARCH, 32'h0000_00AB, 32'h0, want);         // path ends early
        send_op(FUNC_SEARCH, 32'h0000_0001, 32'h0, want);         // inner node, no value
        wait_idle();
        set_key_bytes(3'd4);
    endtask

    task automatic test_pool_exhaust();
        lookup_result_t     want;
        logic [KEY_W-1:0]   first_key;
        logic [KEY_W-1:0]   last_key;
        logic [KEY_W-1:0]   key;
        int                 n;
        send_op(FUNC_CLEAR, $urandom, $urandom, want);
        first_key = $urandom;
        send_op(FUNC_INSERT, first_key, $urandom, want);
        n = 0;
        want.status = 1'b0;
        while (!want.status && n < 80)
        begin
            last_key = $urandom;
            send_op(FUNC_INSERT, last_key, $urandom, want);
            n++;
        end
        send_op(FUNC_INSERT, first_key, $urandom, want);          // existing path, no alloc
        send_op(FUNC_SEARCH, first_key, 32'h0, want);
        send_op(FUNC_SEARCH, last_key, 32'h0, want);              // partial path left behind
        send_op(FUNC_INSERT, $urandom, $urandom, want);
        send_op(FUNC_CLEAR, 32'h0, 32'h0, want);
        key = $urandom;
        send_op(FUNC_INSERT, key, $urandom, want);
        send_op(FUNC_SEARCH, key, 32'h0, want);
    endtask

    task automatic run_episode(input int count);
        lookup_result_t     want;
        logic [KEY_W-1:0]   keys[8];
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  value;
        bit                 fill;
        int                 roll;
        int                 k;
        fill = ($urandom_range(99) < 20);
        if ($urandom_range(1))
            send_op(FUNC_CLEAR, $urandom, $urandom, want);
        keys[0] = $urandom;
        for (k = 1; k < 8; k++)
            keys[k] = keys[$urandom_range(k - 1)] ^ (32'h1 << $urandom_range(31));
        repeat (count)
        begin
            key  = keys[$urandom_range(7)];
            roll = $urandom_range(99);
            if (roll < 10)
                value = 32'h0;
            else if (roll < 20)
                value = 32'hFFFF_FFFF;
            else
                value = $urandom;
            roll = $urandom_range(99);
            if (fill && roll < 70)
                send_op(FUNC_INSERT, $urandom, value, want);
            else if (roll < 40)
                send_op(FUNC_INSERT, key, value, want);
            else if (roll < 80)
                send_op(FUNC_SEARCH, key, value, want);
            else if (roll < 88)
                send_op(FUNC_SEARCH, $urandom, value, want);
            else if (roll < 93)
                send_op(FUNC_SEARCH, key ^ (32'hFFFF_FFFF << (key_bytes * 8)), value, want);
            else if (roll < 96)
                send_op(FUNC_INSERT, $urandom, value, want);
            else if (roll < 98)
                send_op(FUNC_CLEAR, key, value, want);
            else
                send_op(FUNC_UNUSED, $urandom, value, want);
        end
    endtask

    task automatic test_random();
        int plan[13] = '{4, 2, 0, 3, 7, 1, 4, 5, 2, 3, 6, 1, 4};
        int phase_end;
        int p;
        int n;
        for (p = 0; p < 13; p++)
        begin
            wait_idle();
            set_key_bytes(plan[p][KB_W-1:0]);
            steady <= (p == 6);
            phase_end = items_sent + (ITEM_TARGET - HOLD_ITEMS - items_sent) / (13 - p);
            while (items_sent < phase_end)
            begin
                n = $urandom_range(10, 40);
                if (n > phase_end - items_sent)
                    n = phase_end - items_sent;
                run_episode(n);
            end
        end
    endtask

    task automatic test_backpressure();
        lookup_result_t   want;
        logic [KEY_W-1:0] key;
        hold_reqs <= hold_reqs + 1;
        repeat (HOLD_ITEMS / 2)
        begin
            key = $urandom;
            send_op(FUNC_INSERT, key, $urandom, want);
            send_op(FUNC_SEARCH, key, $urandom, want);
        end
    endtask

    initial
    begin : result_check
        lookup_result_t want;
        int             hold_left;
        int             hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("result with no item outstanding, tdata %h",
                                              m_tdata));
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[0] !== want.found)
                        report_mismatch($sformatf("found %b, want %b", m_tdata[0], want.found));
                    if (m_tdata[32:1] !== want.value)
                        report_mismatch($sformatf("result_value %h, want %h",
                                                  m_tdata[32:1], want.value));
                    if (m_tdata[33] !== want.status)
                        report_mismatch($sformatf("status %b, want %b",
                                                  m_tdata[33], want.status));
                end
            end
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_pool_exhaust();
        test_random();
        test_backpressure();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
